// ----- hdl/fmk_pkg.sv -----
// Package for the four-momentum kinematics block: widths, stage positions and constants.
// It depends on nothing; every other file imports it.
package fmk_pkg;

   localparam int CW        = 24;
   localparam int FRAC_BITS = 12;

   localparam int SQ_W   = 2 * CW;
   localparam int ROOT_W = CW;
   localparam int M2_W   = 2 * CW + 1;
   localparam int MASS_W = CW + 1;
   localparam int MAG_W  = CW;
   localparam int RAP_W  = 17;
   localparam int AB_W   = CW + 1;

   localparam int LOG_FRAC  = 28;
   localparam int MANT_FRAC = 30;
   localparam int MANT_W    = MANT_FRAC + 1;
   localparam int EXP_W     = $clog2(AB_W);
   localparam int LOGV_W    = EXP_W + LOG_FRAC;

   localparam int HALF_LN2_W = 29;
   localparam logic [HALF_LN2_W-1:0] HALF_LN2 = 29'd372130559;
   localparam int PROD_W = LOGV_W + HALF_LN2_W;
   localparam int RND_SH = LOG_FRAC + MANT_FRAC - FRAC_BITS;

   localparam int SQRT_OUT = 3 + ROOT_W;
   localparam int LOG_OUT  = 2 + LOG_FRAC;
   localparam int JOIN     = (SQRT_OUT > LOG_OUT) ? SQRT_OUT : LOG_OUT;
   localparam int ROOT_DLY = JOIN - SQRT_OUT;
   localparam int LOG_DLY  = JOIN - LOG_OUT;
   localparam int SIDE_N   = JOIN - 3;
   localparam int LAST     = JOIN + 3;
   localparam int N_STG    = LAST + 1;

   typedef struct packed {
      logic [ROOT_W-1:0] mass;
      logic [ROOT_W-1:0] trans;
      logic [ROOT_W-1:0] spat;
   } roots_type;

   typedef struct packed {
      logic [M2_W-1:0] m2;
      logic            neg;
      logic            ok;
   } side_type;

endpackage

// ----- hdl/fmk_req_if.sv -----
// Request channel of the four-momentum kinematics block: valid, ready and one four-momentum.
// Depends on fmk_pkg.
interface fmk_req_if
   import fmk_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] energy;
   logic signed [CW-1:0] mom_x;
   logic signed [CW-1:0] mom_y;
   logic signed [CW-1:0] mom_z;

   modport source (output valid, energy, mom_x, mom_y, mom_z, input ready);
   modport sink (input valid, energy, mom_x, mom_y, mom_z, output ready);
endinterface

// ----- hdl/fmk_rsp_if.sv -----
// Response channel of the four-momentum kinematics block: valid, ready and one result.
// Depends on fmk_pkg.
interface fmk_rsp_if
   import fmk_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [M2_W-1:0]   mass_squared;
   logic signed [MASS_W-1:0] signed_mass;
   logic [MAG_W-1:0]         transverse_mag;
   logic [MAG_W-1:0]         spatial_mag;
   logic signed [RAP_W-1:0]  rapidity_value;
   logic                     rapidity_valid;

   modport source (output valid, mass_squared, signed_mass, transverse_mag, spatial_mag,
                   rapidity_value, rapidity_valid, input ready);
   modport sink (input valid, mass_squared, signed_mass, transverse_mag, spatial_mag,
                 rapidity_value, rapidity_valid, output ready);
endinterface

// ----- hdl/four_momentum_kinematics.sv -----
// Top level of the four-momentum kinematics block: front stages, square roots, logarithms
// and the rapidity back end. Depends on fmk_pkg, fmk_req_if, fmk_rsp_if, fmk_isqrt, fmk_log2.
//
// Each request carries one four-momentum (energy and three momentum components, signed
// fixed point). Each response carries the Minkowski square, the signed mass, the transverse
// and spatial magnitudes and the rapidity with its valid flag.
// Both channels use valid and ready; a request moves at a clock edge where both are high.
// The block is a fixed pipeline of 34 register stages at the default widths: a request
// passes through each stage in order, and one request is taken in every cycle unless the pipeline holds.
// The depth is set by the 28 squaring stages of the logarithm units, one fraction bit each,
// together with the input stages and the three stages of the rapidity multiply and rounding.
// The square roots take one result bit per stage and are aligned to the logarithms.
// When the receiver holds ready low while a response waits, the whole pipeline holds and
// ready on the request side drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline by clearing all valid bits; data registers are not reset.
module four_momentum_kinematics
   import fmk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   fmk_req_if.sink   req_if,
   fmk_rsp_if.source rsp_if
);
   logic             adv;
   logic [N_STG-1:0] v_ff;

   logic signed [CW-1:0] e0_ff, x0_ff, y0_ff, z0_ff;
   logic [SQ_W-1:0]      sqe1_ff, sqx1_ff, sqy1_ff, sqz1_ff;
   logic [SQ_W-1:0]      sqe1_in, sqx1_in, sqy1_in, sqz1_in;
   logic signed [AB_W-1:0] a1_ff, b1_ff, a1_in, b1_in;
   logic                 ok1_ff, ok1_in;

   logic [SQ_W-1:0]   e2_ff, tr2_ff, sp2_ff;
   logic              ok2_ff;
   logic [MANT_W-1:0] mant_a2_ff, mant_b2_ff, mant_a2_in, mant_b2_in;
   logic [EXP_W-1:0]  exp_a2_ff, exp_b2_ff, exp_a2_in, exp_b2_in;

   logic [M2_W-1:0] m2_3_ff;
   logic [SQ_W-1:0] mag3_ff, tr3_ff, sp3_ff;
   logic            neg3_ff, ok3_ff;

   roots_type         roots_out, roots_j;
   logic [LOGV_W-1:0] loga_out, logb_out, loga_j, logb_j;
   side_type          side_ff [SIDE_N];

   side_type          side4_ff, side5_ff;
   roots_type         roots4_ff, roots5_ff;
   logic              dneg4_ff, dneg5_ff;
   logic [LOGV_W-1:0] dabs4_ff, dabs4_in;
   logic [PROD_W-1:0] prod5_ff;

   logic [M2_W-1:0]   m2_out_ff;
   logic [MASS_W-1:0] mass_out_ff, mass_out_in;
   logic [MAG_W-1:0]  tr_out_ff, sp_out_ff;
   logic [RAP_W-1:0]  rap_out_ff, rap_out_in;
   logic              rapv_out_ff;

   assign adv          = !v_ff[LAST] || rsp_if.ready;
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[N_STG-2:0], req_if.valid};
      end
   end

   always_comb begin
      logic [CW-1:0] ae, ax, ay, az;
      ae = e0_ff[CW-1] ? (~e0_ff + 1'b1) : e0_ff;
      ax = x0_ff[CW-1] ? (~x0_ff + 1'b1) : x0_ff;
      ay = y0_ff[CW-1] ? (~y0_ff + 1'b1) : y0_ff;
      az = z0_ff[CW-1] ? (~z0_ff + 1'b1) : z0_ff;
      sqe1_in = {{CW{1'b0}}, ae} * {{CW{1'b0}}, ae};
      sqx1_in = {{CW{1'b0}}, ax} * {{CW{1'b0}}, ax};
      sqy1_in = {{CW{1'b0}}, ay} * {{CW{1'b0}}, ay};
      sqz1_in = {{CW{1'b0}}, az} * {{CW{1'b0}}, az};
      a1_in   = AB_W'(e0_ff) + AB_W'(x0_ff);
      b1_in   = AB_W'(e0_ff) - AB_W'(x0_ff);
      ok1_in  = (a1_in > 0) && (b1_in > 0);
   end

   always_comb begin
      logic [AB_W-1:0]           xa, xb;
      logic [AB_W+MANT_FRAC-1:0] wa, wb;
      xa = ok1_ff ? a1_ff : AB_W'(1);
      xb = ok1_ff ? b1_ff : AB_W'(1);
      exp_a2_in = '0;
      exp_b2_in = '0;
      for (int i = 0; i < AB_W; i++) begin
         if (xa[i]) exp_a2_in = EXP_W'(i);
         if (xb[i]) exp_b2_in = EXP_W'(i);
      end
      wa = {xa, {MANT_FRAC{1'b0}}} >> exp_a2_in;
      wb = {xb, {MANT_FRAC{1'b0}}} >> exp_b2_in;
      mant_a2_in = wa[MANT_W-1:0];
      mant_b2_in = wb[MANT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e0_ff <= req_if.energy;
         x0_ff <= req_if.mom_x;
         y0_ff <= req_if.mom_y;
         z0_ff <= req_if.mom_z;

         sqe1_ff <= sqe1_in;
         sqx1_ff <= sqx1_in;
         sqy1_ff <= sqy1_in;
         sqz1_ff <= sqz1_in;
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         ok1_ff  <= ok1_in;

         e2_ff      <= sqe1_ff;
         tr2_ff     <= sqy1_ff + sqz1_ff;
         sp2_ff     <= sqx1_ff + sqy1_ff + sqz1_ff;
         ok2_ff     <= ok1_ff;
         mant_a2_ff <= mant_a2_in;
         mant_b2_ff <= mant_b2_in;
         exp_a2_ff  <= exp_a2_in;
         exp_b2_ff  <= exp_b2_in;

         m2_3_ff <= {1'b0, e2_ff} - {1'b0, sp2_ff};
         neg3_ff <= e2_ff < sp2_ff;
         mag3_ff <= (e2_ff < sp2_ff) ? (sp2_ff - e2_ff) : (e2_ff - sp2_ff);
         tr3_ff  <= tr2_ff;
         sp3_ff  <= sp2_ff;
         ok3_ff  <= ok2_ff;
      end
   end

   fmk_isqrt u_sqrt_mass (.clock, .en(adv), .value_in(mag3_ff), .root_out(roots_out.mass));
   fmk_isqrt u_sqrt_tr (.clock, .en(adv), .value_in(tr3_ff), .root_out(roots_out.trans));
   fmk_isqrt u_sqrt_sp (.clock, .en(adv), .value_in(sp3_ff), .root_out(roots_out.spat));

   fmk_log2 u_log_a (.clock, .en(adv), .mant_in(mant_a2_ff), .exp_in(exp_a2_ff),
                     .log_out(loga_out));
   fmk_log2 u_log_b (.clock, .en(adv), .mant_in(mant_b2_ff), .exp_in(exp_b2_ff),
                     .log_out(logb_out));

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{m2: m2_3_ff, neg: neg3_ff, ok: ok3_ff};
         for (int j = 1; j < SIDE_N; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   generate
      if (ROOT_DLY > 0) begin : g_root_dly
         roots_type rd_ff [ROOT_DLY];
         always_ff @(posedge clock) begin
            if (adv) begin
               rd_ff[0] <= roots_out;
               for (int j = 1; j < ROOT_DLY; j++) begin
                  rd_ff[j] <= rd_ff[j-1];
               end
            end
         end
         assign roots_j = rd_ff[ROOT_DLY-1];
      end else begin : g_root_direct
         assign roots_j = roots_out;
      end
      if (LOG_DLY > 0) begin : g_log_dly
         logic [LOGV_W-1:0] la_ff [LOG_DLY];
         logic [LOGV_W-1:0] lb_ff [LOG_DLY];
         always_ff @(posedge clock) begin
            if (adv) begin
               la_ff[0] <= loga_out;
               lb_ff[0] <= logb_out;
               for (int j = 1; j < LOG_DLY; j++) begin
                  la_ff[j] <= la_ff[j-1];
                  lb_ff[j] <= lb_ff[j-1];
               end
            end
         end
         assign loga_j = la_ff[LOG_DLY-1];
         assign logb_j = lb_ff[LOG_DLY-1];
      end else begin : g_log_direct
         assign loga_j = loga_out;
         assign logb_j = logb_out;
      end
   endgenerate

   logic [LOGV_W:0] diff_j;
   assign diff_j   = {1'b0, loga_j} - {1'b0, logb_j};
   assign dabs4_in = diff_j[LOGV_W] ? LOGV_W'(~diff_j + 1'b1) : diff_j[LOGV_W-1:0];

   always_comb begin
      logic [PROD_W:0] rsum;
      logic [PROD_W:0] rsh;
      logic [ROOT_W:0] mass_ext;
      rsum = {1'b0, prod5_ff} + ((PROD_W+1)'(1) << (RND_SH - 1));
      rsh  = rsum >> RND_SH;
      if (!side5_ff.ok) begin
         rap_out_in = '0;
      end else if (dneg5_ff) begin
         rap_out_in = ~rsh[RAP_W-1:0] + 1'b1;
      end else begin
         rap_out_in = rsh[RAP_W-1:0];
      end
      mass_ext    = {1'b0, roots5_ff.mass};
      mass_out_in = side5_ff.neg ? MASS_W'(~mass_ext + 1'b1) : MASS_W'(mass_ext);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side4_ff  <= side_ff[SIDE_N-1];
         roots4_ff <= roots_j;
         dneg4_ff  <= diff_j[LOGV_W];
         dabs4_ff  <= dabs4_in;

         side5_ff  <= side4_ff;
         roots5_ff <= roots4_ff;
         dneg5_ff  <= dneg4_ff;
         prod5_ff  <= {{HALF_LN2_W{1'b0}}, dabs4_ff} * {{LOGV_W{1'b0}}, HALF_LN2};

         m2_out_ff   <= side5_ff.m2;
         mass_out_ff <= mass_out_in;
         tr_out_ff   <= roots5_ff.trans;
         sp_out_ff   <= roots5_ff.spat;
         rap_out_ff  <= rap_out_in;
         rapv_out_ff <= side5_ff.ok;
      end
   end

   assign rsp_if.valid          = v_ff[LAST];
   assign rsp_if.mass_squared   = m2_out_ff;
   assign rsp_if.signed_mass    = mass_out_ff;
   assign rsp_if.transverse_mag = tr_out_ff;
   assign rsp_if.spatial_mag    = sp_out_ff;
   assign rsp_if.rapidity_value = rap_out_ff;
   assign rsp_if.rapidity_valid = rapv_out_ff;

   a_take_enters : assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> v_ff[0])
      else $error("accepted request did not enter the pipeline");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("pipeline moved while stalled");

   a_rap_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.rapidity_valid) |-> (rsp_if.rapidity_value == '0))
      else $error("invalid rapidity is not zero");

   a_mass_sign : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.signed_mass[MASS_W-1]) |-> rsp_if.mass_squared[M2_W-1])
      else $error("negative mass with non-negative square");

   a_mag_order : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.spatial_mag >= rsp_if.transverse_mag))
      else $error("spatial magnitude below transverse magnitude");
endmodule

// ----- hdl/fmk_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, floor result.
// Depends on fmk_pkg; the enable is the pipeline advance of the top level.
module fmk_isqrt
   import fmk_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [SQ_W-1:0]   value_in,
   output logic [ROOT_W-1:0] root_out
);
   localparam int REM_W = ROOT_W + 2;

   logic [SQ_W-1:0]   n_ff [ROOT_W];
   logic [ROOT_W-1:0] q_ff [ROOT_W];
   logic [REM_W-1:0]  r_ff [ROOT_W];
   logic [SQ_W-1:0]   n_in [ROOT_W];
   logic [ROOT_W-1:0] q_in [ROOT_W];
   logic [REM_W-1:0]  r_in [ROOT_W];

   always_comb begin
      logic [SQ_W-1:0]   src_n;
      logic [ROOT_W-1:0] src_q;
      logic [REM_W-1:0]  src_r;
      logic [REM_W+1:0]  rr;
      logic [REM_W+2:0]  diff;
      for (int k = 0; k < ROOT_W; k++) begin
         if (k == 0) begin
            src_n = value_in;
            src_q = '0;
            src_r = '0;
         end else begin
            src_n = n_ff[k-1];
            src_q = q_ff[k-1];
            src_r = r_ff[k-1];
         end
         rr   = {src_r, src_n[SQ_W-1 -: 2]};
         diff = {1'b0, rr} - {3'b000, src_q, 2'b01};
         n_in[k] = src_n << 2;
         if (!diff[REM_W+2]) begin
            r_in[k] = diff[REM_W-1:0];
            q_in[k] = {src_q[ROOT_W-2:0], 1'b1};
         end else begin
            r_in[k] = rr[REM_W-1:0];
            q_in[k] = {src_q[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            n_ff[k] <= n_in[k];
            q_ff[k] <= q_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign root_out = q_ff[ROOT_W-1];
endmodule

// ----- hdl/fmk_log2.sv -----
// Pipelined base-two logarithm by repeated squaring of a normalised mantissa, one
// fraction bit per stage. Depends on fmk_pkg.
module fmk_log2
   import fmk_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [MANT_W-1:0] mant_in,
   input  logic [EXP_W-1:0]  exp_in,
   output logic [LOGV_W-1:0] log_out
);
   logic [MANT_W-1:0]   m_ff [LOG_FRAC];
   logic [LOG_FRAC-1:0] f_ff [LOG_FRAC];
   logic [EXP_W-1:0]    e_ff [LOG_FRAC];
   logic [MANT_W-1:0]   m_in [LOG_FRAC];
   logic [LOG_FRAC-1:0] f_in [LOG_FRAC];
   logic [EXP_W-1:0]    e_in [LOG_FRAC];

   always_comb begin
      logic [MANT_W-1:0]   src_m;
      logic [LOG_FRAC-1:0] src_f;
      logic [2*MANT_W-1:0] prod;
      logic [MANT_W:0]     sq;
      for (int k = 0; k < LOG_FRAC; k++) begin
         if (k == 0) begin
            src_m   = mant_in;
            src_f   = '0;
            e_in[k] = exp_in;
         end else begin
            src_m   = m_ff[k-1];
            src_f   = f_ff[k-1];
            e_in[k] = e_ff[k-1];
         end
         prod = {{MANT_W{1'b0}}, src_m} * {{MANT_W{1'b0}}, src_m};
         sq   = prod[MANT_FRAC+MANT_W:MANT_FRAC];
         if (sq[MANT_W]) begin
            m_in[k] = sq[MANT_W:1];
            f_in[k] = {src_f[LOG_FRAC-2:0], 1'b1};
         end else begin
            m_in[k] = sq[MANT_W-1:0];
            f_in[k] = {src_f[LOG_FRAC-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < LOG_FRAC; k++) begin
            m_ff[k] <= m_in[k];
            f_ff[k] <= f_in[k];
            e_ff[k] <= e_in[k];
         end
      end
   end

   assign log_out = {e_ff[LOG_FRAC-1], f_ff[LOG_FRAC-1]};
endmodule
